### rtl/cau_pkg.sv
package cau_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF  = 8;

    typedef enum logic [1:0] {
        MODE_ADD = 2'd0,
        MODE_SUB = 2'd1,
        MODE_MUL = 2'd2,
        MODE_DIV = 2'd3
    } t_mode;

endpackage

### rtl/cau_div_step.sv
module cau_div_step #(
    parameter int REM_WIDTH = 34,
    parameter int DEN_WIDTH = 32,
    parameter int SHIFT     = 0
) (
    input  logic [REM_WIDTH-1:0] i_rem,
    input  logic [DEN_WIDTH-1:0] i_den,
    output logic [REM_WIDTH-1:0] o_rem,
    output logic                 o_bit
);

    logic [REM_WIDTH-1:0] w_sub;

    // One restoring step: the divisor is aligned to this quotient bit.
    assign w_sub = REM_WIDTH'(i_den) << SHIFT;
    assign o_bit = (i_rem >= w_sub);
    assign o_rem = o_bit ? (i_rem - w_sub) : i_rem;

endmodule

### rtl/complex_arithmetic_unit.sv
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_ready     i_a_real, i_a_imag, i_b_real, i_b_imag, i_mode
// result    out        o_out_valid / i_out_ready   o_res_real, o_res_imag, o_operands_equal,
//                                                  o_overflow, o_divide_by_zero
//
// Every item passes through registered stages in order: input, products, sums,
// magnitudes, the divider range check, one divider stage per quotient bit, and
// saturation. A new item can enter in every cycle unless a stall has backed up to the input.
// Reset (synchronous, active low) clears only the valid bits of the stages.
// Each stage holds its item while the next stage is full and stalled, so a stall at
// the output fills bubbles first and only then stops the input.
module complex_arithmetic_unit #(
    parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic signed [DATA_WIDTH-1:0] i_a_real,
    input  logic signed [DATA_WIDTH-1:0] i_a_imag,
    input  logic signed [DATA_WIDTH-1:0] i_b_real,
    input  logic signed [DATA_WIDTH-1:0] i_b_imag,
    input  cau_pkg::t_mode               i_mode,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic signed [DATA_WIDTH-1:0] o_res_real,
    output logic signed [DATA_WIDTH-1:0] o_res_imag,
    output logic                         o_operands_equal,
    output logic                         o_overflow,
    output logic                         o_divide_by_zero
);

    import cau_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int PW = 2 * W;          // product width
    localparam int SW = 2 * W + 2;      // signed sum width
    localparam int MW = 2 * W + 1;      // magnitude width
    localparam int RW = 3 * W + FRAC_BITS + 2;   // divider remainder width
    localparam int NS = W + 7;          // number of stages
    localparam int ST_DIV0 = 5;         // first quotient-bit stage
    localparam int ST_SAT  = NS - 1;

    localparam logic [MW-1:0] HALF = MW'(1) << (W - 1);

    // One record travels through all stages; each stage fills the fields it owns.
    typedef struct packed {
        t_mode                 mode;
        logic                  eq;
        logic signed [W-1:0]   ar;
        logic signed [W-1:0]   ai;
        logic signed [W-1:0]   br;
        logic signed [W-1:0]   bi;
        logic signed [PW-1:0]  p_rr;
        logic signed [PW-1:0]  p_ii;
        logic signed [PW-1:0]  p_ri;
        logic signed [PW-1:0]  p_ir;
        logic signed [PW-1:0]  p_bb1;
        logic signed [PW-1:0]  p_bb2;
        logic signed [SW-1:0]  s_re;
        logic signed [SW-1:0]  s_im;
        logic [PW-1:0]         den;
        logic                  dz;
        logic                  neg_re;
        logic                  neg_im;
        logic [MW-1:0]         mag_re;
        logic [MW-1:0]         mag_im;
        logic [RW-1:0]         rem_re;
        logic [RW-1:0]         rem_im;
        logic                  big_re;
        logic                  big_im;
        logic [W-1:0]          res_re;
        logic [W-1:0]          res_im;
        logic                  ovf;
    } t_stage;

    t_stage r_st  [NS];
    t_stage n_st  [NS];
    logic   r_vld [NS];
    logic   w_en  [NS+1];

    assign w_en[NS] = i_out_ready;

    genvar k;
    generate
        for (k = 0; k < NS; k++) begin : g_stage
            t_stage w_src;
            logic   w_src_vld;

            // A stage takes a new item when it is empty or its item moves on.
            assign w_en[k] = !r_vld[k] || w_en[k+1];

            if (k == 0) begin : g_in
                always_comb begin
                    w_src      = '0;
                    w_src.mode = i_mode;
                    w_src.ar   = i_a_real;
                    w_src.ai   = i_a_imag;
                    w_src.br   = i_b_real;
                    w_src.bi   = i_b_imag;
                    w_src.eq   = (i_a_real == i_b_real) && (i_a_imag == i_b_imag);
                end
                assign w_src_vld = i_in_valid;
                assign n_st[k]   = w_src;
            end else begin : g_mid
                assign w_src     = r_st[k-1];
                assign w_src_vld = r_vld[k-1];
            end

            if (k == 1) begin : g_mul
                // Six products in parallel; the last two form the squared magnitude of b, the divisor.
                always_comb begin
                    n_st[k]       = w_src;
                    n_st[k].p_rr  = w_src.ar * w_src.br;
                    n_st[k].p_ii  = w_src.ai * w_src.bi;
                    n_st[k].p_ri  = w_src.ar * w_src.bi;
                    n_st[k].p_ir  = w_src.ai * w_src.br;
                    n_st[k].p_bb1 = w_src.br * w_src.br;
                    n_st[k].p_bb2 = w_src.bi * w_src.bi;
                end
            end else if (k == 2) begin : g_sum
                always_comb begin
                    n_st[k]     = w_src;
                    n_st[k].den = $unsigned(w_src.p_bb1) + $unsigned(w_src.p_bb2);
                    case (w_src.mode)
                        MODE_ADD: begin
                            n_st[k].s_re = SW'(w_src.ar) + SW'(w_src.br);
                            n_st[k].s_im = SW'(w_src.ai) + SW'(w_src.bi);
                        end
                        MODE_SUB: begin
                            n_st[k].s_re = SW'(w_src.ar) - SW'(w_src.br);
                            n_st[k].s_im = SW'(w_src.ai) - SW'(w_src.bi);
                        end
                        MODE_MUL: begin
                            n_st[k].s_re = SW'(w_src.p_rr) - SW'(w_src.p_ii);
                            n_st[k].s_im = SW'(w_src.p_ri) + SW'(w_src.p_ir);
                        end
                        default: begin
                            // Numerator of a * conj(b).
                            n_st[k].s_re = SW'(w_src.p_rr) + SW'(w_src.p_ii);
                            n_st[k].s_im = SW'(w_src.p_ir) - SW'(w_src.p_ri);
                        end
                    endcase
                end
            end else if (k == 3) begin : g_mag
                always_comb begin
                    logic [SW-1:0] a_re;
                    logic [SW-1:0] a_im;
                    n_st[k]        = w_src;
                    n_st[k].neg_re = w_src.s_re[SW-1];
                    n_st[k].neg_im = w_src.s_im[SW-1];
                    a_re = w_src.s_re[SW-1] ? -w_src.s_re : w_src.s_re;
                    a_im = w_src.s_im[SW-1] ? -w_src.s_im : w_src.s_im;
                    n_st[k].dz     = (w_src.den == '0);
                    n_st[k].rem_re = RW'(a_re[MW-1:0]) << FRAC_BITS;
                    n_st[k].rem_im = RW'(a_im[MW-1:0]) << FRAC_BITS;
                    case (w_src.mode)
                        MODE_MUL: begin
                            // Shifting the magnitude truncates toward zero.
                            n_st[k].mag_re = a_re[MW-1:0] >> FRAC_BITS;
                            n_st[k].mag_im = a_im[MW-1:0] >> FRAC_BITS;
                        end
                        MODE_DIV: begin
                            n_st[k].mag_re = '0;
                            n_st[k].mag_im = '0;
                        end
                        default: begin
                            n_st[k].mag_re = a_re[MW-1:0];
                            n_st[k].mag_im = a_im[MW-1:0];
                        end
                    endcase
                end
            end else if (k == 4) begin : g_big
                // A quotient of 2^(W+1) or more saturates whatever its sign.
                always_comb begin
                    n_st[k]        = w_src;
                    n_st[k].big_re = w_src.rem_re >= (RW'(w_src.den) << (W + 1));
                    n_st[k].big_im = w_src.rem_im >= (RW'(w_src.den) << (W + 1));
                end
            end else if (k >= ST_DIV0 && k < ST_SAT) begin : g_div
                logic [RW-1:0] w_rem_re;
                logic [RW-1:0] w_rem_im;
                logic          w_bit_re;
                logic          w_bit_im;

                cau_div_step #(
                    .REM_WIDTH (RW),
                    .DEN_WIDTH (PW),
                    .SHIFT     (W - (k - ST_DIV0))
                ) u_step_re (
                    .i_rem (w_src.rem_re),
                    .i_den (w_src.den),
                    .o_rem (w_rem_re),
                    .o_bit (w_bit_re)
                );

                cau_div_step #(
                    .REM_WIDTH (RW),
                    .DEN_WIDTH (PW),
                    .SHIFT     (W - (k - ST_DIV0))
                ) u_step_im (
                    .i_rem (w_src.rem_im),
                    .i_den (w_src.den),
                    .o_rem (w_rem_im),
                    .o_bit (w_bit_im)
                );

                always_comb begin
                    n_st[k] = w_src;
                    if (w_src.mode == MODE_DIV) begin
                        n_st[k].rem_re = w_rem_re;
                        n_st[k].rem_im = w_rem_im;
                        n_st[k].mag_re = {w_src.mag_re[MW-2:0], w_bit_re};
                        n_st[k].mag_im = {w_src.mag_im[MW-2:0], w_bit_im};
                    end
                end
            end else if (k == ST_SAT) begin : g_sat
                always_comb begin
                    logic is_div;
                    logic hi_re;
                    logic hi_im;
                    n_st[k] = w_src;
                    is_div  = (w_src.mode == MODE_DIV);
                    hi_re = w_src.neg_re ? ((is_div && w_src.big_re) || w_src.mag_re > HALF)
                                         : ((is_div && w_src.big_re) || w_src.mag_re > HALF - 1'b1);
                    hi_im = w_src.neg_im ? ((is_div && w_src.big_im) || w_src.mag_im > HALF)
                                         : ((is_div && w_src.big_im) || w_src.mag_im > HALF - 1'b1);
                    if (hi_re) begin
                        n_st[k].res_re = w_src.neg_re ? {1'b1, {(W-1){1'b0}}}
                                                      : {1'b0, {(W-1){1'b1}}};
                    end else begin
                        n_st[k].res_re = w_src.neg_re ? -w_src.mag_re[W-1:0]
                                                      : w_src.mag_re[W-1:0];
                    end
                    if (hi_im) begin
                        n_st[k].res_im = w_src.neg_im ? {1'b1, {(W-1){1'b0}}}
                                                      : {1'b0, {(W-1){1'b1}}};
                    end else begin
                        n_st[k].res_im = w_src.neg_im ? -w_src.mag_im[W-1:0]
                                                      : w_src.mag_im[W-1:0];
                    end
                    n_st[k].ovf = hi_re || hi_im;
                    n_st[k].dz  = is_div && w_src.dz;
                    if (is_div && w_src.dz) begin
                        n_st[k].res_re = '0;
                        n_st[k].res_im = '0;
                        n_st[k].ovf    = 1'b0;
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (w_en[k]) begin
                    r_vld[k] <= w_src_vld;
                end
            end

            always_ff @(posedge i_clk) begin
                if (w_en[k]) begin
                    r_st[k] <= n_st[k];
                end
            end
        end
    endgenerate

    assign o_in_ready       = w_en[0];
    assign o_out_valid      = r_vld[ST_SAT];
    assign o_res_real       = r_st[ST_SAT].res_re;
    assign o_res_imag       = r_st[ST_SAT].res_im;
    assign o_operands_equal = r_st[ST_SAT].eq;
    assign o_overflow       = r_st[ST_SAT].ovf;
    assign o_divide_by_zero = r_st[ST_SAT].dz;

endmodule

### sim/complex_arithmetic_unit_checker.sv
`timescale 1ns / 100ps

module complex_arithmetic_unit_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic signed [15:0]  i_a_real,
    input  logic signed [15:0]  i_a_imag,
    input  logic signed [15:0]  i_b_real,
    input  logic signed [15:0]  i_b_imag,
    input  cau_pkg::t_mode      i_mode,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  logic signed [15:0]  i_res_real,
    input  logic signed [15:0]  i_res_imag,
    input  logic                i_operands_equal,
    input  logic                i_overflow,
    input  logic                i_divide_by_zero,
    output int                  o_fail_count,
    output int                  o_pending,
    output int                  o_result_count
);
    import cau_pkg::*;

    typedef struct packed {
        logic signed [15:0] re;
        logic signed [15:0] im;
        logic               eq;
        logic               ovf;
        logic               dz;
    } t_answer;

    t_answer answer_q[$];

    localparam longint MAX_POS = 32767;
    localparam longint MIN_NEG = -32768;

    // Clamp one part to the 16-bit signed range, noting saturation.
    function automatic logic signed [15:0] clamp16(input longint v, inout logic ovf);
        if (v > MAX_POS) begin
            ovf = 1'b1;
            return MAX_POS[15:0];
        end
        if (v < MIN_NEG) begin
            ovf = 1'b1;
            return MIN_NEG[15:0];
        end
        return v[15:0];
    endfunction

    // Quotient of num * 2^8 / den truncated toward zero. The magnitude is capped
    // at 2^15 + 1, which is already beyond the range, so saturation is unchanged.
    function automatic longint scaled_quotient(input longint num, input longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (mag <<< 8) / den;
        if (q > 32769) q = 32769;
        return (num < 0) ? -q : q;
    endfunction

    function automatic t_answer complex_result(input longint ar, input longint ai,
                                               input longint br, input longint bi,
                                               input t_mode md);
        t_answer r;
        longint re, im, den;
        logic ovf;
        ovf = 1'b0;
        r.dz = 1'b0;
        re = 0;
        im = 0;
        case (md)
            MODE_ADD: begin
                re = ar + br;
                im = ai + bi;
            end
            MODE_SUB: begin
                re = ar - br;
                im = ai - bi;
            end
            MODE_MUL: begin
                // Shift of a magnitude: truncation toward zero.
                re = ar * br - ai * bi;
                im = ar * bi + ai * br;
                re = (re < 0) ? -((-re) >>> 8) : (re >>> 8);
                im = (im < 0) ? -((-im) >>> 8) : (im >>> 8);
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.dz = 1'b1;
                end else begin
                    re = scaled_quotient(ar * br + ai * bi, den);
                    im = scaled_quotient(ai * br - ar * bi, den);
                end
            end
        endcase
        r.re = clamp16(re, ovf);
        r.im = clamp16(im, ovf);
        r.ovf = ovf;
        r.eq = (ar == br) && (ai == bi);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            answer_q.delete();
            o_fail_count <= 0;
            o_result_count <= 0;
        end else begin
            if (i_in_valid && i_in_ready)
                answer_q.push_back(complex_result(i_a_real, i_a_imag, i_b_real,
                                                  i_b_imag, i_mode));
            if (i_out_valid && i_out_ready) begin
                o_result_count <= o_result_count + 1;
                if (answer_q.size() == 0) begin
                    if (o_fail_count < 10)
                        $display("ERROR: result with nothing expected at %0t", $realtime);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (want.re !== i_res_real || want.im !== i_res_imag ||
                        want.eq !== i_operands_equal || want.ovf !== i_overflow ||
                        want.dz !== i_divide_by_zero) begin
                        if (o_fail_count < 10)
                            $display("ERROR: re %0d/%0d im %0d/%0d eq %b/%b ovf %b/%b dz %b/%b",
                                     want.re, i_res_real, want.im, i_res_imag,
                                     want.eq, i_operands_equal, want.ovf, i_overflow,
                                     want.dz, i_divide_by_zero);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
    end

    assign o_pending = answer_q.size();
endmodule

### sim/complex_arithmetic_unit_tb.sv
`timescale 1ns / 100ps

module complex_arithmetic_unit_tb;
    import cau_pkg::*;

    localparam int RANDOM_ITEMS = 1600;
    localparam int CYCLE_LIMIT  = 400000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic signed [15:0] i_a_real = '0;
    logic signed [15:0] i_a_imag = '0;
    logic signed [15:0] i_b_real = '0;
    logic signed [15:0] i_b_imag = '0;
    t_mode              i_mode = MODE_ADD;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic signed [15:0] o_res_real;
    logic signed [15:0] o_res_imag;
    logic               o_operands_equal;
    logic               o_overflow;
    logic               o_divide_by_zero;

    int fail_count;
    int pending;
    int result_count;
    int cycle_count = 0;
    int items_sent = 0;

    // Set while the receiver is made to hold off for a long stretch.
    logic long_hold = 1'b0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    complex_arithmetic_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .i_a_real(i_a_real), .i_a_imag(i_a_imag),
        .i_b_real(i_b_real), .i_b_imag(i_b_imag), .i_mode(i_mode),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_res_real(o_res_real), .o_res_imag(o_res_imag),
        .o_operands_equal(o_operands_equal), .o_overflow(o_overflow),
        .o_divide_by_zero(o_divide_by_zero)
    );

    complex_arithmetic_unit_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready),
        .i_a_real(i_a_real), .i_a_imag(i_a_imag),
        .i_b_real(i_b_real), .i_b_imag(i_b_imag), .i_mode(i_mode),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_res_real(o_res_real), .i_res_imag(o_res_imag),
        .i_operands_equal(o_operands_equal), .i_overflow(o_overflow),
        .i_divide_by_zero(o_divide_by_zero),
        .o_fail_count(fail_count), .o_pending(pending), .o_result_count(result_count)
    );

    // A gap length: mostly zero or short, now and then long.
    function automatic int gap_length();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // An operand part: extremes, small values near zero, or anything at all.
    function automatic logic signed [15:0] operand_part();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'(signed'($urandom_range(0, 1024)) - 512);
            3: return 16'sh0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // Offer one item and hold it until the block accepts it.
    task automatic send_item(input logic signed [15:0] ar, input logic signed [15:0] ai,
                             input logic signed [15:0] br, input logic signed [15:0] bi,
                             input t_mode md);
        i_in_valid <= 1'b1;
        i_a_real <= ar;
        i_a_imag <= ai;
        i_b_real <= br;
        i_b_imag <= bi;
        i_mode <= md;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_random(input int gap);
        logic signed [15:0] ar, ai, br, bi;
        t_mode md;
        ar = operand_part();
        ai = operand_part();
        md = t_mode'($urandom_range(0, 3));
        // Now and then reuse a so that equality and the a/a quotient get hit.
        if ($urandom_range(0, 9) == 0) begin
            br = ar;
            bi = ai;
        end else begin
            br = operand_part();
            bi = operand_part();
        end
        send_item(ar, ai, br, bi, md);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // The receiver: random stalls, or one long hold while long_hold is set.
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_out_ready <= 1'b0;
        else if (long_hold)
            i_out_ready <= 1'b0;
        else if ($urandom_range(0, 99) < 8)
            i_out_ready <= 1'b0;
        else
            i_out_ready <= ($urandom_range(0, 9) != 0) || !i_out_ready;
    end

    // Watchdog on the whole run.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL complex_arithmetic_unit");
            $finish;
        end
    end

    initial begin
        t_mode md;
        int n;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed items: every mode on extremes, zero divisors, equal operands.
        for (int m = 0; m < 4; m++) begin
            md = t_mode'(m);
            send_item(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, md);
            send_item(16'sh8000, 16'sh8000, 16'sh7FFF, 16'sh8000, md);
            send_item(16'sh0100, 16'shFF00, 16'sh0000, 16'sh0000, md);
            send_item(16'sh0180, 16'sh0040, 16'sh0180, 16'sh0040, md);
        end
        // Corner cases: divisions by tiny and huge divisors, zero over zero, and one product.
        send_item(16'sh7FFF, 16'sh8000, 16'sh0001, 16'sh0000, MODE_DIV);
        send_item(16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, MODE_DIV);
        send_item(16'sh8000, 16'sh0000, 16'sh0000, 16'sh0001, MODE_DIV);
        send_item(16'sh0001, 16'shFFFF, 16'sh8000, 16'sh8000, MODE_DIV);
        send_item(16'shFFFF, 16'sh0003, 16'sh0100, 16'shFF00, MODE_MUL);

        // The sender pauses until everything in flight has come back.
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);

        // Long receiver hold while items keep coming, so the pipeline fills
        // up and the input stalls.
        long_hold <= 1'b1;
        fork
            begin
                repeat (120) @(posedge i_clk);
                long_hold <= 1'b0;
            end
            for (int k = 0; k < 60; k++) send_random(0);
        join
        i_in_valid <= 1'b0;

        // Random part: bursts without gaps alternate with gappy stretches.
        n = 0;
        while (n < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                for (int k = 0; k < 40 && n < RANDOM_ITEMS; k++, n++) send_random(0);
            end else begin
                for (int k = 0; k < 40 && n < RANDOM_ITEMS; k++, n++)
                    send_random(gap_length());
            end
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d items in all four modes, %0d results checked,", items_sent,
                 result_count);
        $display("with saturation, zero divisors and input back-pressure exercised.");
        if (fail_count == 0 && pending == 0)
            $display("PASS complex_arithmetic_unit");
        else
            $display("FAIL complex_arithmetic_unit");
        $finish;
    end
endmodule

### complex_arithmetic_unit.f
rtl/cau_pkg.sv
rtl/cau_div_step.sv
rtl/complex_arithmetic_unit.sv
sim/complex_arithmetic_unit_checker.sv
sim/complex_arithmetic_unit_tb.sv
